// ===== hw/rtl/mxm_pkg.sv =====
// Shared types and codes for the max XOR multiset block.
`timescale 1ns / 1ps
`default_nettype none
package mxm_pkg;
  localparam int FUNC_W   = 2;
  localparam int FIELD_W  = 30;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 20;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  max_xor;
    logic [STATUS_W-1:0] status;
  } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/max_xor_multiset.sv =====
// Max XOR multiset: a table of values with copy counts and a scanning sequencer.
// Every transaction runs the same steps once accepted: a sweep of all entries in S_SCAN,
// S_DRAIN for the last RAM read, S_DO to decide and write the entry, S_WRITE, and S_OUT before done.
// A new transaction is taken only back in S_IDLE; the sweep reads one entry per cycle from
// the single RAM port, and one shared compare unit checks every entry.
// Reset is synchronous; its clearing pass, busy high, leaves value 0 stored once. done is one cycle.
`timescale 1ns / 1ps
`default_nettype none
module max_xor_multiset #(
  parameter int VALUE_BITS = 30,
  parameter int CAPACITY   = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire mxm_pkg::cmd_t    cmd,
  output logic                  busy,
  output logic                  done,
  output mxm_pkg::result_t      result
);
  import mxm_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = AW + 1;
  localparam int ENT_W = 1 + COUNT_W + VALUE_BITS;
  localparam logic [CW-1:0] LAST = CW'(CAPACITY - 1);
  localparam logic [COUNT_W-1:0] CMAX = '1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DO    = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [CW-1:0] ptr;
  logic [AW-1:0] rd_idx;
  logic rd_live;
  logic [FUNC_W-1:0] func;
  logic [VALUE_BITS-1:0] x;
  logic hit, free_found, any;
  logic [AW-1:0] hit_idx, free_idx;
  logic [COUNT_W-1:0] hit_cnt;
  logic [VALUE_BITS-1:0] best;
  logic [STATUS_W-1:0] st;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic e_valid;
  logic [COUNT_W-1:0] e_cnt;
  logic [VALUE_BITS-1:0] e_val, t;

  assign {e_valid, e_cnt, e_val} = ram_rdata;
  assign t = x ^ e_val;

  mxm_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ptr[AW-1:0];
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (ptr == '0) ? {1'b1, COUNT_W'(1), {VALUE_BITS{1'b0}}} : '0;
      end
      S_DO: begin
        ram_addr = hit ? hit_idx : free_idx;
        if (func == FUNC_INSERT && hit && hit_cnt != CMAX) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, hit_cnt + COUNT_W'(1), x};
        end else if (func == FUNC_INSERT && !hit && free_found) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, COUNT_W'(1), x};
        end else if (func == FUNC_DELETE && hit) begin
          ram_we    = 1'b1;
          ram_wdata = {hit_cnt != COUNT_W'(1), hit_cnt - COUNT_W'(1), x};
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      ptr     <= '0;
      rd_live <= 1'b0;
      done    <= 1'b0;
    end else begin
      done    <= (state == S_OUT);
      rd_idx  <= ptr[AW-1:0];
      rd_live <= (state == S_SCAN);
      // Entry read last cycle is on ram_rdata now.
      if (rd_live && e_valid) begin
        if (e_val == x && !hit) begin
          hit <= 1'b1; hit_idx <= rd_idx; hit_cnt <= e_cnt;
        end
        if (!any || t > best) best <= t;
        any <= 1'b1;
      end
      if (rd_live && !e_valid && !free_found) begin
        free_found <= 1'b1; free_idx <= rd_idx;
      end
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + CW'(1);
          if (ptr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            func <= cmd.func;
            x    <= VALUE_BITS'(cmd.operand);
            hit <= 1'b0; free_found <= 1'b0; any <= 1'b0; best <= '0;
            ptr <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          ptr <= ptr + CW'(1);
          if (ptr == LAST) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_DO;
        S_DO: begin
          if (func == FUNC_INSERT && hit && hit_cnt == CMAX) begin
            st <= ST_LIMIT;
          end else if (func == FUNC_INSERT && !hit && !free_found) begin
            st <= ST_FULL;
          end else if ((func == FUNC_DELETE && !hit) || (func == FUNC_QUERY && !any)) begin
            st <= ST_ABSENT;
          end else begin
            st <= ST_OK;
          end
          state <= S_WRITE;
        end
        S_WRITE: state <= S_OUT;
        S_OUT: begin
          result.status  <= st;
          result.max_xor <= (func == FUNC_QUERY && any) ? FIELD_W'(best) : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_OUT) else $error("result without sequence end");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy after result");
  a_zero_nonquery: assert property (@(posedge clk) disable iff (rst)
    (done && func != FUNC_QUERY) |-> result.max_xor == '0) else $error("bad max_xor");
endmodule
`default_nettype wire

// ===== hw/rtl/mxm_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mxm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
